[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the translator checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DPLT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DPLT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/dplt_pkg.sv]
// ---------------------------------------------------------------------------
// Demand paging translator package
// Widths, codes and shared types of the LRU address translator.
// ---------------------------------------------------------------------------
package dplt_pkg;

  localparam int OFFS_W     = 12;
  localparam int PAGE_W     = 10;
  localparam int VA_W       = 22;
  localparam int PA_W       = 16;
  localparam int DATA_W     = 8;
  localparam int NUM_FRAMES = 16;
  localparam int FRAME_W    = $clog2(NUM_FRAMES);
  localparam int CNT_W      = FRAME_W + 1;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_UPDATE
  } dplt_state_e;

  typedef struct packed {
    logic capture;
    logic commit;
  } dplt_cmd_t;

  typedef struct packed {
    logic              hit;
    logic [PA_W-1:0]   physical_address;
    logic [PAGE_W-1:0] fill_page;
    logic [FRAME_W-1:0] fill_frame;
    logic              evict_valid;
    logic [PAGE_W-1:0] evict_page;
    logic              writeback_needed;
    logic              write_enable;
    logic [DATA_W-1:0] store_data;
  } dplt_rsp_t;

endpackage

[hdl/dplt_if.sv]
// ---------------------------------------------------------------------------
// Translator channel interfaces
// Valid/ready channels for access requests and translation results.
// ---------------------------------------------------------------------------
interface dplt_req_if import dplt_pkg::*;;
  logic              valid;
  logic              ready;
  logic              command;
  logic [VA_W-1:0]   virtual_address;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, command, virtual_address, write_data, input ready);
  modport sink   (input valid, command, virtual_address, write_data, output ready);
endinterface

interface dplt_rsp_if import dplt_pkg::*;;
  logic               valid;
  logic               ready;
  logic               hit;
  logic [PA_W-1:0]    physical_address;
  logic [PAGE_W-1:0]  fill_page;
  logic [FRAME_W-1:0] fill_frame;
  logic               evict_valid;
  logic [PAGE_W-1:0]  evict_page;
  logic               writeback_needed;
  logic               write_enable;
  logic [DATA_W-1:0]  store_data;

  modport source (output valid, hit, physical_address, fill_page, fill_frame, evict_valid,
                  evict_page, writeback_needed, write_enable, store_data, input ready);
  modport sink   (input valid, hit, physical_address, fill_page, fill_frame, evict_valid,
                  evict_page, writeback_needed, write_enable, store_data, output ready);
endinterface

[hdl/demand_paging_lru_translator_unit.sv]
// ---------------------------------------------------------------------------
// Demand paging LRU translator
// Translates byte accesses to RAM addresses and plans page fills/evictions.
// ---------------------------------------------------------------------------
// Each request is a byte read or write to a 22-bit virtual address whose page
// number sits above 12 offset bits. The unit keeps 16 RAM frames. A request
// whose page owns a frame hits, is translated to {frame, offset} and makes
// that frame the most recently used. A miss takes the next free frame in
// ascending order, or, once all frames are in use, the least recently used
// frame; the result then names the page to fill, the frame to fill, the
// displaced page and whether it was dirty and needs a write-back. A write
// marks its page dirty. Copying pages and bytes is left to external memory.
// A request is first captured, and its page is compared against the owner
// of every in-use frame; it is then committed: the recency order, the owner
// table and the dirty bits are updated and the result register is loaded.
// The commit waits while a previous result is still held at the output,
// but a new request is taken while that result waits. No clearing pass is
// needed after reset: residency follows from the frame owner table and the
// count of frames in use, which reset clears at once.
// ---------------------------------------------------------------------------
module demand_paging_lru_translator_unit import dplt_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  dplt_req_if.sink    req_i,
  dplt_rsp_if.source  rsp_o
);

  // Command strobes from the controller to the datapath.
  dplt_cmd_t ctrl_cmd;
  // Result register contents.
  dplt_rsp_t rsp_data;

  // The controller accepts a request only from its idle state, then commits
  // it once the result register is free or being drained.
  dplt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (ctrl_cmd)
  );

  // The datapath holds the frame owners, dirty bits and the recency list,
  // where entry 0 is the least recently used frame.
  dplt_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (ctrl_cmd),
    .command_i         (req_i.command),
    .virtual_address_i (req_i.virtual_address),
    .write_data_i      (req_i.write_data),
    .rsp_o             (rsp_data)
  );

  // Result fields are driven straight from the result register.
  assign rsp_o.hit              = rsp_data.hit;
  assign rsp_o.physical_address = rsp_data.physical_address;
  assign rsp_o.fill_page        = rsp_data.fill_page;
  assign rsp_o.fill_frame       = rsp_data.fill_frame;
  assign rsp_o.evict_valid      = rsp_data.evict_valid;
  assign rsp_o.evict_page       = rsp_data.evict_page;
  assign rsp_o.writeback_needed = rsp_data.writeback_needed;
  assign rsp_o.write_enable     = rsp_data.write_enable;
  assign rsp_o.store_data       = rsp_data.store_data;

endmodule

[hdl/dplt_ctrl.sv]
// ---------------------------------------------------------------------------
// Translator controller
// Sequences capture and commit of one request and owns the result valid.
// ---------------------------------------------------------------------------
module dplt_ctrl import dplt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  output logic      rsp_valid_o,
  input  logic      rsp_ready_i,
  output dplt_cmd_t cmd_o
);

  dplt_state_e state_q, state_d;
  logic        rsp_valid_q, rsp_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    rsp_valid_d = rsp_valid_q & ~rsp_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        // A finished result may still wait at the output here.
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          cmd_o.commit = 1'b1;
          rsp_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rsp_valid_o = rsp_valid_q;

endmodule

[hdl/dplt_dp.sv]
// ---------------------------------------------------------------------------
// Translator datapath
// Frame owner table, dirty bits, recency order and the result register.
// ---------------------------------------------------------------------------
module dplt_dp import dplt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dplt_cmd_t         cmd_i,
  input  logic              command_i,
  input  logic [VA_W-1:0]   virtual_address_i,
  input  logic [DATA_W-1:0] write_data_i,
  output dplt_rsp_t         rsp_o
);

  // Captured request and lookup result.
  logic               cmd_q;
  logic [PAGE_W-1:0]  page_q;
  logic [OFFS_W-1:0]  offset_q;
  logic [DATA_W-1:0]  wdata_q;
  logic               hit_q;
  logic [FRAME_W-1:0] hframe_q;

  // Translation state.
  logic [PAGE_W-1:0]     owner_q [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] dirty_q;
  logic [FRAME_W-1:0]    order_q [NUM_FRAMES];
  logic [FRAME_W-1:0]    order_d [NUM_FRAMES];
  logic [CNT_W-1:0]      used_q;
  dplt_rsp_t             rsp_q, rsp_d;

  logic [PAGE_W-1:0]     page_in;
  logic [NUM_FRAMES-1:0] own_match;
  logic                  hit_d;
  logic [FRAME_W-1:0]    hframe_d;

  logic                  full;
  logic                  cmd_wr;
  logic [FRAME_W-1:0]    victim_frame;
  logic [FRAME_W-1:0]    frame_sel;
  logic [NUM_FRAMES-1:0] order_match;
  logic [NUM_FRAMES-1:0] shift_sel;
  logic                  reorder;
  logic [CNT_W-1:0]      last_pos;
  logic [(NUM_FRAMES+1)*FRAME_W-1:0] order_flat;

  assign page_in = virtual_address_i[VA_W-1 -: PAGE_W];

  // A page is resident exactly when an in-use frame names it as owner.
  always_comb begin
    own_match = '0;
    hframe_d  = '0;
    for (int f = 0; f < NUM_FRAMES; f++) begin
      if ((CNT_W'(f) < used_q) && (owner_q[f] == page_in)) begin
        own_match[f] = 1'b1;
        hframe_d     = hframe_d | FRAME_W'(f);
      end
    end
  end
  assign hit_d = |own_match;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q    <= command_i;
      page_q   <= page_in;
      offset_q <= virtual_address_i[OFFS_W-1:0];
      wdata_q  <= write_data_i;
      hit_q    <= hit_d;
      hframe_q <= hframe_d;
    end
  end

  assign full         = (used_q == CNT_W'(NUM_FRAMES));
  assign cmd_wr       = (cmd_q == CMD_WRITE);
  assign victim_frame = order_q[0];
  assign frame_sel    = hit_q ? hframe_q : (full ? victim_frame : used_q[FRAME_W-1:0]);
  assign last_pos     = used_q - CNT_W'(1);

  always_comb begin
    order_flat = '0;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      order_flat[i*FRAME_W +: FRAME_W] = order_q[i];
    end
  end

  // Entries at and above the hit position, or all of them on a full miss, move down by one.
  always_comb begin
    order_match = '0;
    shift_sel   = '0;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      order_match[i] = (CNT_W'(i) < used_q) && (order_q[i] == hframe_q);
    end
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (hit_q) begin
        shift_sel[i] = |(order_match & ({NUM_FRAMES{1'b1}} >> (NUM_FRAMES - 1 - i)));
      end else begin
        shift_sel[i] = full;
      end
    end
  end
  assign reorder = hit_q ? (|order_match) : full;

  always_comb begin
    for (int i = 0; i < NUM_FRAMES; i++) begin
      order_d[i] = order_q[i];
      if (reorder) begin
        if (CNT_W'(i) == last_pos) begin
          order_d[i] = frame_sel;
        end else if ((CNT_W'(i) < last_pos) && shift_sel[i]) begin
          order_d[i] = order_flat[(i+1)*FRAME_W +: FRAME_W];
        end
      end else if (!hit_q && !full && (CNT_W'(i) == used_q)) begin
        order_d[i] = used_q[FRAME_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      for (int i = 0; i < NUM_FRAMES; i++) begin
        order_q[i] <= order_d[i];
      end
      if (!hit_q) begin
        owner_q[frame_sel] <= page_q;
      end
      dirty_q[frame_sel] <= hit_q ? (dirty_q[frame_sel] | cmd_wr) : cmd_wr;
      rsp_q              <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (cmd_i.commit && !hit_q && !full) begin
      used_q <= used_q + CNT_W'(1);
    end
  end

  always_comb begin
    rsp_d                  = '0;
    rsp_d.hit              = hit_q;
    rsp_d.physical_address = {frame_sel, offset_q};
    rsp_d.fill_page        = hit_q ? '0 : page_q;
    rsp_d.fill_frame       = hit_q ? '0 : frame_sel;
    rsp_d.evict_valid      = !hit_q && full;
    rsp_d.evict_page       = (!hit_q && full) ? owner_q[victim_frame] : '0;
    rsp_d.writeback_needed = !hit_q && full && dirty_q[victim_frame];
    rsp_d.write_enable     = cmd_wr;
    rsp_d.store_data       = wdata_q;
  end

  assign rsp_o = rsp_q;

endmodule

[hdl/dplt_checker.sv]
// ---------------------------------------------------------------------------
// Translator port checker
// Watches the top level ports for result consistency and request pacing.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dplt_checker import dplt_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               req_valid_i,
  input logic               req_ready_i,
  input logic               rsp_valid_i,
  input logic               rsp_ready_i,
  input logic               hit_i,
  input logic [PA_W-1:0]    physical_address_i,
  input logic [PAGE_W-1:0]  fill_page_i,
  input logic [FRAME_W-1:0] fill_frame_i,
  input logic               evict_valid_i,
  input logic [PAGE_W-1:0]  evict_page_i,
  input logic               writeback_needed_i
);

  // A hit never plans a fill or an eviction.
  `DPLT_ASSERT_IMP(a_hit_no_fill, clk_i, rst_ni, rsp_valid_i && hit_i, fill_page_i == '0 && fill_frame_i == '0 && !evict_valid_i, "hit result carries fill or eviction")

  // Without an eviction there is no victim page and no write-back.
  `DPLT_ASSERT_IMP(a_no_evict_clean, clk_i, rst_ni, rsp_valid_i && !evict_valid_i, evict_page_i == '0 && !writeback_needed_i, "eviction fields set without eviction")

  // Each request must pass through the commit state before the next one is taken.
  `DPLT_ASSERT_NXT(a_req_spacing, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i, "request taken in back-to-back cycles")

  // A stalled result is held unchanged.
  `DPLT_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(physical_address_i) && $stable(hit_i), "stalled result changed")

endmodule

bind demand_paging_lru_translator_unit dplt_checker u_dplt_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .req_valid_i        (req_i.valid),
  .req_ready_i        (req_i.ready),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .hit_i              (rsp_o.hit),
  .physical_address_i (rsp_o.physical_address),
  .fill_page_i        (rsp_o.fill_page),
  .fill_frame_i       (rsp_o.fill_frame),
  .evict_valid_i      (rsp_o.evict_valid),
  .evict_page_i       (rsp_o.evict_page),
  .writeback_needed_i (rsp_o.writeback_needed)
);

[tb/dplt_tb_checker.sv]
// ---------------------------------------------------------------------------
// Translator result checker
// Watches the request and result channels of the LRU translator, predicts
// every translation and compares each result with the oldest prediction.
// ---------------------------------------------------------------------------
module dplt_tb_checker import dplt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  dplt_req_if  req_mon,
  dplt_rsp_if  rsp_mon,
  output int   mismatches_o,
  output int   pending_o,
  output int   results_o,
  output int   hits_o,
  output int   evictions_o,
  output int   writebacks_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PAGES = 1 << PAGE_W;

  // Shadow page table and frame bookkeeping.
  logic                resident [NUM_PAGES];
  logic                modified [NUM_PAGES];
  logic [FRAME_W-1:0]  frame_of_page [NUM_PAGES];
  logic [PAGE_W-1:0]   frame_page [NUM_FRAMES];
  logic [FRAME_W-1:0]  lru_list [NUM_FRAMES];  // entry 0 is least recent
  int                  frames_used;

  dplt_rsp_t pending_translations [$];
  int mismatches, results, hits, evictions, writebacks;

  // Moves the frame at list position pos to the most recent end.
  function automatic void promote_frame(int pos, logic [FRAME_W-1:0] frame);
    for (int i = pos; i + 1 < frames_used; i++) lru_list[i] = lru_list[i + 1];
    lru_list[frames_used - 1] = frame;
  endfunction

  function automatic dplt_rsp_t translate_access(logic cmd, logic [VA_W-1:0] va,
                                                 logic [DATA_W-1:0] wdata);
    dplt_rsp_t          r;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
    logic [PAGE_W-1:0]  victim;
    r = '0;
    page = va[OFFS_W +: PAGE_W];
    if (resident[page]) begin
      r.hit = 1'b1;
      frame = frame_of_page[page];
      for (int i = 0; i < frames_used; i++) begin
        if (lru_list[i] == frame) begin
          promote_frame(i, frame);
          break;
        end
      end
    end else begin
      if (frames_used < NUM_FRAMES) begin
        frame = FRAME_W'(frames_used);
        lru_list[frames_used] = frame;
        frames_used++;
      end else begin
        frame = lru_list[0];
        victim = frame_page[frame];
        r.evict_valid = 1'b1;
        r.evict_page = victim;
        r.writeback_needed = modified[victim];
        resident[victim] = 1'b0;
        modified[victim] = 1'b0;
        promote_frame(0, frame);
      end
      frame_page[frame] = page;
      resident[page] = 1'b1;
      modified[page] = 1'b0;
      frame_of_page[page] = frame;
      r.fill_page = page;
      r.fill_frame = frame;
    end
    if (cmd == CMD_WRITE) modified[page] = 1'b1;
    r.physical_address = {frame, va[OFFS_W-1:0]};
    r.write_enable = cmd;
    r.store_data = wdata;
    return r;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $realtime, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    dplt_rsp_t want;
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PAGES; p++) begin
        resident[p] = 1'b0;
        modified[p] = 1'b0;
      end
      frames_used = 0;
      pending_translations.delete();
      mismatches = 0;
      results = 0;
      hits = 0;
      evictions = 0;
      writebacks = 0;
    end else begin
      if (req_mon.valid && req_mon.ready) begin
        want = translate_access(req_mon.command, req_mon.virtual_address,
                                req_mon.write_data);
        hits += int'(want.hit);
        evictions += int'(want.evict_valid);
        writebacks += int'(want.writeback_needed);
        pending_translations.push_back(want);
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        results++;
        if (pending_translations.size() == 0) begin
          mismatches++;
          $display("%0t: result with no request waiting, expected none, actual pa 0x%0h",
                   $realtime, rsp_mon.physical_address);
        end else begin
          want = pending_translations.pop_front();
          compare_field("hit", 32'(want.hit), 32'(rsp_mon.hit));
          compare_field("physical_address", 32'(want.physical_address),
                        32'(rsp_mon.physical_address));
          compare_field("fill_page", 32'(want.fill_page), 32'(rsp_mon.fill_page));
          compare_field("fill_frame", 32'(want.fill_frame), 32'(rsp_mon.fill_frame));
          compare_field("evict_valid", 32'(want.evict_valid), 32'(rsp_mon.evict_valid));
          compare_field("evict_page", 32'(want.evict_page), 32'(rsp_mon.evict_page));
          compare_field("writeback_needed", 32'(want.writeback_needed),
                        32'(rsp_mon.writeback_needed));
          compare_field("write_enable", 32'(want.write_enable), 32'(rsp_mon.write_enable));
          compare_field("store_data", 32'(want.store_data), 32'(rsp_mon.store_data));
        end
      end
    end
    mismatches_o <= mismatches;
    pending_o <= pending_translations.size();
    results_o <= results;
    hits_o <= hits;
    evictions_o <= evictions;
    writebacks_o <= writebacks;
  end

endmodule

[tb/tb_top.sv]
// ---------------------------------------------------------------------------
// LRU translator testbench
// Drives byte read and write requests into the demand paging translator,
// stalls the result side at random and reports the checker's verdict.
// ---------------------------------------------------------------------------
module tb_top import dplt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PAGES = 1 << PAGE_W;
  localparam int PHASES    = 6;
  localparam int PHASE_LEN = 200;

  logic clk_i;
  logic rst_ni;

  dplt_req_if req_ch ();
  dplt_rsp_if rsp_ch ();

  int mismatches, pending, results, hits, evictions, writebacks;

  demand_paging_lru_translator_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  dplt_tb_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_ch),
    .rsp_mon      (rsp_ch),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .results_o    (results),
    .hits_o       (hits),
    .evictions_o  (evictions),
    .writebacks_o (writebacks)
  );

  // 50 MHz clock.
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Generous timeout bound on the run.
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Hot page set for the current random phase.
  int unsigned hot_pages [40];
  int unsigned hot_count;
  bit          gaps_on;

  // Presents one request and holds it until the translator accepts it. The
  // valid line stays high on return, so a back-to-back request never lowers
  // and raises it in the same step.
  task automatic offer_access(input logic cmd, input logic [VA_W-1:0] va,
                              input logic [DATA_W-1:0] wdata);
    req_ch.valid           <= 1'b1;
    req_ch.command         <= cmd;
    req_ch.virtual_address <= va;
    req_ch.write_data      <= wdata;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // Random gap after a request: mostly none, some short, a few long.
  task automatic sender_gap();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (!gaps_on || pick < 60) len = 0;
    else if (pick < 92) len = $urandom_range(1, 3);
    else len = $urandom_range(8, 40);
    if (len > 0) begin
      req_ch.valid <= 1'b0;
      repeat (len) @(posedge clk_i);
    end
  endtask

  // Stops offering requests until every predicted result has come back.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic page_access(input int unsigned page, input logic [OFFS_W-1:0] offs,
                             input logic cmd, input logic [DATA_W-1:0] wdata);
    offer_access(cmd, {page[PAGE_W-1:0], offs}, wdata);
    sender_gap();
  endtask

  // Reset and stimulus.
  initial begin
    int unsigned page;
    logic [OFFS_W-1:0] offs;
    logic [VA_W-1:0] va;
    rst_ni                 <= 1'b0;
    req_ch.valid           <= 1'b0;
    req_ch.command         <= CMD_READ;
    req_ch.virtual_address <= '0;
    req_ch.write_data      <= '0;
    gaps_on = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The top page with the top offset and full data, then
    // page 0 at offset 0 read with zero data; a read still passes its data.
    page_access(NUM_PAGES - 1, '1, CMD_WRITE, 8'hFF);
    page_access(0, '0, CMD_READ, 8'h00);
    // A hit on a dirty page moves it to the most recent end.
    page_access(NUM_PAGES - 1, 12'h123, CMD_READ, 8'hA5);
    // Fill the remaining free frames in order, writing every other page.
    for (int p = 1; p <= 14; p++)
      page_access(p, OFFS_W'($urandom), (p % 2) ? CMD_WRITE : CMD_READ, DATA_W'($urandom));
    // Page 0 becomes most recent, so the dirty top page is now the oldest.
    page_access(0, 12'hFFF, CMD_READ, 8'h3C);
    // All frames in use: evict a dirty page, another dirty one, then a clean one.
    page_access(500, 12'h001, CMD_WRITE, 8'h5A);
    page_access(501, 12'h800, CMD_READ, 8'h00);
    page_access(502, 12'h7FF, CMD_READ, 8'hFF);
    // Hit on the page that took over an evicted frame.
    page_access(500, 12'h010, CMD_WRITE, 8'h81);
    // The sender waits here until every result has come back.
    drain_results();

    // Random phases. Most requests fall into a hot set sized around the
    // number of frames, so hits, fills and LRU evictions all occur often;
    // the rest are fully random addresses.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: hot_count = 8;
        1: hot_count = 16;
        2: hot_count = 17;
        3: hot_count = 20;
        4: hot_count = 40;
        default: hot_count = 12;
      endcase
      for (int k = 0; k < hot_count; k++) hot_pages[k] = $urandom_range(0, NUM_PAGES - 1);
      // Two phases run with no sender gaps at all.
      gaps_on = !(ph == 1 || ph == 4);
      for (int n = 0; n < PHASE_LEN; n++) begin
        if ($urandom_range(0, 99) < 85) begin
          page = hot_pages[$urandom_range(0, hot_count - 1)];
          case ($urandom_range(0, 9))
            0: offs = '0;
            1: offs = '1;
            default: offs = OFFS_W'($urandom);
          endcase
          va = {page[PAGE_W-1:0], offs};
        end else begin
          va = VA_W'($urandom);
        end
        offer_access(($urandom_range(0, 1) == 1) ? CMD_WRITE : CMD_READ, va,
                     DATA_W'($urandom));
        sender_gap();
      end
      if (ph == 2) drain_results();
    end

    // Let every outstanding result come back, then keep the clock running
    // in case the translator emits something nobody asked for.
    drain_results();
    repeat (20) @(posedge clk_i);

    $display("Checked %0d translations: %0d hits, %0d misses.",
             results, hits, results - hits);
    $display("LRU evictions: %0d, of which %0d needed a write-back.", evictions, writebacks);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Result side. Ready toggles in random runs; once, after 300 results, it is
  // held low while requests keep coming, so that the translator fills up and
  // must stall its request side.
  initial begin
    bit held_off;
    int pick;
    int run_len;
    int stall_len;
    held_off = 1'b0;
    rsp_ch.ready <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (!held_off && results >= 300) begin
        held_off = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (250) @(posedge clk_i);
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        run_len = $urandom_range(1, 4);
        stall_len = $urandom_range(0, 3);
      end else if (pick < 90) begin
        run_len = $urandom_range(20, 60);
        stall_len = 0;
      end else begin
        run_len = $urandom_range(1, 2);
        stall_len = $urandom_range(15, 40);
      end
      rsp_ch.ready <= 1'b1;
      repeat (run_len) @(posedge clk_i);
      if (stall_len > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall_len) @(posedge clk_i);
      end
    end
  end

endmodule

[sim.f]
+incdir+hdl
hdl/dplt_pkg.sv
hdl/dplt_if.sv
hdl/dplt_ctrl.sv
hdl/dplt_dp.sv
hdl/demand_paging_lru_translator_unit.sv
hdl/dplt_checker.sv
tb/dplt_tb_checker.sv
tb/tb_top.sv
